[hdl/set_assoc_tag_store_lru_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the LRU tag store
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_TAG_STORE_LRU_DEFINES_SVH
`define SET_ASSOC_TAG_STORE_LRU_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SATS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tag store check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SATS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tag store check failed");
`else
`define SATS_ASSERT_NOW(lbl, ante, cons)
`define SATS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/satslru_pkg.sv]
// ----------------------------------------------------------------------------
// satslru_pkg
// Sizes, field layout and codes shared by the LRU tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package satslru_pkg;

    localparam int WAYS       = 8;
    localparam int SET_BITS   = 6;
    localparam int ADDR_BITS  = 48;
    localparam int STAMP_BITS = 32;

    localparam int NUM_SETS     = 1 << SET_BITS;
    localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Victim search is a binary tree over the ways, padded to a power of two.
    localparam int REDUCE_LVLS = $clog2(WAYS);
    localparam int PAD_WAYS    = 1 << REDUCE_LVLS;
    localparam int LVL_BITS    = (REDUCE_LVLS > 0) ? $clog2(REDUCE_LVLS + 1) : 1;

    localparam int OFFSET_BITS = 4;
    localparam int OFFSET_MAX  = (1 << OFFSET_BITS) - 1;
    localparam int TSHIFT_W    = $clog2(OFFSET_MAX + SET_BITS + 1);
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 4'd6;

    localparam logic [1:0] LS_INVALID = 2'd3;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_SET    = 2'd1,
        CMD_SET_HIT = 2'd2,
        CMD_PEEK   = 2'd3
    } cmd_t;

    // Input word layout.
    localparam int IN_ADDR_LSB  = 0;
    localparam int IN_NST_LSB   = IN_ADDR_LSB + ADDR_BITS;
    localparam int IN_TOUCH_LSB = IN_NST_LSB + 2;
    localparam int IN_TIME_LSB  = IN_TOUCH_LSB + 1;
    localparam int IN_USED      = IN_TIME_LSB + STAMP_BITS;
    localparam int IN_DATA_BITS = ((IN_USED + 7) / 8) * 8;

    // Output word layout.
    localparam int OUT_HIT_LSB    = 0;
    localparam int OUT_LSTATE_LSB = 1;
    localparam int OUT_VVALID_LSB = 3;
    localparam int OUT_VADDR_LSB  = 4;
    localparam int OUT_VSTATE_LSB = OUT_VADDR_LSB + ADDR_BITS;
    localparam int OUT_USED       = OUT_VSTATE_LSB + 2;
    localparam int OUT_DATA_BITS  = ((OUT_USED + 7) / 8) * 8;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [STAMP_BITS-1:0] stamp;
        logic [1:0]            state;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_BITS = $bits(row_t);

endpackage

`default_nettype wire

[hdl/satslru_ram.sv]
// ----------------------------------------------------------------------------
// satslru_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module satslru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/set_assoc_tag_store_lru.sv]
// ----------------------------------------------------------------------------
// set_assoc_tag_store_lru
// Tag and state store of a set-associative cache with timestamp LRU.
// ----------------------------------------------------------------------------
// Usage. Commands enter on the s_ stream: s_tuser holds the command, s_tdata
// the address, new state, touch flag and reference time. Every command gives
// exactly one result word on the m_ stream: hit flag, prior line state and
// the victim of an allocation, if any. The offset width register is written
// through cfg_valid/cfg_data while the block is idle; cfg_ready is always high.
//
// One command is in flight at a time. A whole set (all ways) sits in one row
// of a synchronous RAM; the row is read when the word is accepted, examined,
// the oldest way is found by a pairwise tree that takes one level per cycle,
// and the updated row is written back. The states after acceptance are S_LOOK,
// S_REDUCE for each tree level and S_WB, which writes the row and the result
// register together and waits there while the receiver holds the old result.
//
// Reset (rst_n low, asynchronous) clears a valid bit per set, so every line
// reads as invalid at once, and sets the offset width to six. When the
// receiver stalls, the result waits in the output register; the block may
// finish the following command only once that register has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_tag_store_lru_defines.svh"

module set_assoc_tag_store_lru
    import satslru_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Command stream.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // s_tdata, lowest bit up: address, new_state, touch, ref_time, zero fill.
    input  wire logic [IN_DATA_BITS-1:0]   s_tdata,
    // s_tuser: cmd.
    input  wire logic [1:0]                s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // m_tdata, lowest bit up: hit, line_state, victim_valid, victim_address,
    // victim_state, zero fill.
    output logic [OUT_DATA_BITS-1:0]       m_tdata,
    // Offset width register.
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [OFFSET_BITS-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_REDUCE,
        S_WB
    } state_t;

    state_t                    state_reg;
    logic [OFFSET_BITS-1:0]    offset_reg;
    logic [NUM_SETS-1:0]       row_vld_reg;
    logic                      row_vld_rd_reg;

    // Latched command.
    cmd_t                      cmd_reg;
    logic [ADDR_BITS-1:0]      addr_reg;
    logic [1:0]                nst_reg;
    logic                      touch_reg;
    logic [STAMP_BITS-1:0]     now_reg;
    logic [SET_IDX_BITS-1:0]   set_reg;

    // Examined row.
    row_t                      row_reg;
    logic                      hit_reg;
    logic [WAY_BITS-1:0]       hit_way_reg;
    logic                      any_inv_reg;
    logic [WAY_BITS-1:0]       inv_way_reg;

    // Victim search tree.
    logic [STAMP_BITS-1:0]     cand_stamp_reg [PAD_WAYS];
    logic [WAY_BITS-1:0]       cand_idx_reg   [PAD_WAYS];
    logic [LVL_BITS-1:0]       lvl_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [OUT_DATA_BITS-1:0]  out_data_reg;

    logic                      accept;
    logic                      wb_go;
    logic [ADDR_BITS-1:0]      in_addr;
    logic [ADDR_BITS-1:0]      in_shifted;
    logic [SET_IDX_BITS-1:0]   in_set;
    logic [SET_IDX_BITS-1:0]   idx_mask;
    logic [ROW_BITS-1:0]       ram_rdata;
    row_t                      eff_row;
    logic [TSHIFT_W-1:0]       tshift;
    logic [ADDR_BITS-1:0]      tag_mask;
    logic [WAYS-1:0]           match;
    logic                      hit_c;
    logic [WAY_BITS-1:0]       hit_way_c;
    logic                      any_inv_c;
    logic [WAY_BITS-1:0]       inv_way_c;
    row_t                      new_row;
    logic                      res_hit;
    logic [1:0]                res_lstate;
    logic                      res_vvalid;
    logic [ADDR_BITS-1:0]      res_vaddr;
    logic [1:0]                res_vstate;
    logic [WAY_BITS-1:0]       alloc_way;
    logic [OUT_DATA_BITS-1:0]  res_word;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign wb_go     = !out_valid_reg || m_tready;

    // Set index from the incoming address.
    assign in_addr    = s_tdata[IN_ADDR_LSB +: ADDR_BITS];
    assign in_shifted = in_addr >> offset_reg;
    assign idx_mask   = SET_IDX_BITS'((64'd1 << SET_BITS) - 64'd1);
    assign in_set     = in_shifted[SET_IDX_BITS-1:0] & idx_mask;

    satslru_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .clk   (clk),
        .we    (state_reg == S_WB && wb_go),
        .waddr (set_reg),
        .wdata (new_row),
        .re    (accept),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    // A set never written since reset reads as all invalid.
    always_comb
    begin
        eff_row = row_t'(ram_rdata);
        if (!row_vld_rd_reg)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                eff_row[w].state = LS_INVALID;
            end
        end
    end

    // Tag compare: all address bits above the set index.
    assign tshift   = TSHIFT_W'(offset_reg) + TSHIFT_W'(SET_BITS);
    assign tag_mask = {ADDR_BITS{1'b1}} << tshift;

    always_comb
    begin
        match     = '0;
        hit_c     = 1'b0;
        hit_way_c = '0;
        any_inv_c = 1'b0;
        inv_way_c = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = (eff_row[w].state != LS_INVALID) &&
                       (((eff_row[w].addr ^ addr_reg) & tag_mask) == '0);
        end
        // Lowest matching way wins.
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_c     = 1'b1;
                hit_way_c = WAY_BITS'(w);
            end
        end
        // Highest invalid way is the allocation target.
        for (int w = 0; w < WAYS; w++)
        begin
            if (eff_row[w].state == LS_INVALID)
            begin
                any_inv_c = 1'b1;
                inv_way_c = WAY_BITS'(w);
            end
        end
    end

    // Write-back row and result.
    always_comb
    begin
        new_row    = row_reg;
        res_hit    = hit_reg;
        res_lstate = LS_INVALID;
        res_vvalid = 1'b0;
        res_vaddr  = '0;
        res_vstate = LS_INVALID;
        alloc_way  = any_inv_reg ? inv_way_reg : cand_idx_reg[0];
        if (hit_reg)
        begin
            res_lstate = row_reg[hit_way_reg].state;
            unique case (cmd_reg)
                CMD_LOOKUP:
                begin
                    if (touch_reg)
                    begin
                        new_row[hit_way_reg].stamp = now_reg;
                    end
                end
                CMD_SET, CMD_SET_HIT:
                begin
                    new_row[hit_way_reg].state = nst_reg;
                end
                CMD_PEEK:
                begin
                    new_row = row_reg;
                end
                default:
                begin
                    new_row = row_reg;
                end
            endcase
        end
        else if (cmd_reg == CMD_SET && nst_reg != LS_INVALID)
        begin
            // No free way: the oldest line is evicted and reported.
            if (!any_inv_reg)
            begin
                res_vvalid = 1'b1;
                res_vaddr  = row_reg[alloc_way].addr;
                res_vstate = row_reg[alloc_way].state;
            end
            new_row[alloc_way].addr  = addr_reg;
            new_row[alloc_way].stamp = now_reg;
            new_row[alloc_way].state = nst_reg;
        end

        res_word = '0;
        res_word[OUT_HIT_LSB]                 = res_hit;
        res_word[OUT_LSTATE_LSB +: 2]         = res_lstate;
        res_word[OUT_VVALID_LSB]              = res_vvalid;
        res_word[OUT_VADDR_LSB +: ADDR_BITS]  = res_vaddr;
        res_word[OUT_VSTATE_LSB +: 2]         = res_vstate;
    end

    // Sequencer, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            offset_reg    <= OFFSET_RESET;
            row_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            lvl_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end

            // A new result replaces the old one in the same cycle it is taken.
            if (state_reg == S_WB && wb_go)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_word;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    lvl_reg <= '0;
                    if (REDUCE_LVLS > 0)
                    begin
                        state_reg <= S_REDUCE;
                    end
                    else
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_REDUCE:
                begin
                    lvl_reg <= lvl_reg + 1'b1;
                    if (lvl_reg == LVL_BITS'(REDUCE_LVLS - 1))
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (wb_go)
                    begin
                        state_reg            <= S_IDLE;
                        row_vld_reg[set_reg] <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= cmd_t'(s_tuser);
            addr_reg       <= in_addr;
            nst_reg        <= s_tdata[IN_NST_LSB +: 2];
            touch_reg      <= s_tdata[IN_TOUCH_LSB];
            now_reg        <= s_tdata[IN_TIME_LSB +: STAMP_BITS];
            set_reg        <= in_set;
            row_vld_rd_reg <= row_vld_reg[in_set];
        end

        if (state_reg == S_LOOK)
        begin
            row_reg     <= eff_row;
            hit_reg     <= hit_c;
            hit_way_reg <= hit_way_c;
            any_inv_reg <= any_inv_c;
            inv_way_reg <= inv_way_c;
            for (int k = 0; k < PAD_WAYS; k++)
            begin
                if (k < WAYS)
                begin
                    cand_stamp_reg[k] <= eff_row[k].stamp;
                end
                else
                begin
                    cand_stamp_reg[k] <= {STAMP_BITS{1'b1}};
                end
                cand_idx_reg[k] <= WAY_BITS'(k);
            end
        end
        else if (state_reg == S_REDUCE)
        begin
            // One tree level: ties keep the lower way.
            for (int k = 0; k < PAD_WAYS / 2; k++)
            begin
                if (cand_stamp_reg[2*k+1] < cand_stamp_reg[2*k])
                begin
                    cand_stamp_reg[k] <= cand_stamp_reg[2*k+1];
                    cand_idx_reg[k]   <= cand_idx_reg[2*k+1];
                end
                else
                begin
                    cand_stamp_reg[k] <= cand_stamp_reg[2*k];
                    cand_idx_reg[k]   <= cand_idx_reg[2*k];
                end
            end
        end
    end

    // A write-back always leaves a fresh result word and frees the input side.
    `SATS_ASSERT_NEXT(a_wb_result, state_reg == S_WB && wb_go, m_tvalid && s_tready)
    // A word is never accepted while another command is in flight.
    `SATS_ASSERT_NEXT(a_one_in_flight, accept, !s_tready)
    // A result never reports both a hit and an eviction.
    `SATS_ASSERT_NOW(a_hit_no_victim, m_tvalid,
                     !(m_tdata[OUT_HIT_LSB] && m_tdata[OUT_VVALID_LSB]))
    // The written set is marked valid after its write-back.
    `SATS_ASSERT_NEXT(a_row_marked, state_reg == S_WB && wb_go,
                      row_vld_reg[$past(set_reg)])

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the LRU tag store of a set-associative cache
// Commands go in on the s_ stream and a shadow copy of every set predicts the
// result word of each one. Directed checks of fills, evictions, state changes
// and field extremes come first, then random traffic aimed at a few busy sets
// under several offset widths. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb;
    import satslru_pkg::*;

    // Coherence states that the block stores. Invalid comes from the package.
    localparam logic [1:0] ST_MODIFIED  = 2'd0;
    localparam logic [1:0] ST_EXCLUSIVE = 2'd1;
    localparam logic [1:0] ST_SHARED    = 2'd2;

    localparam int NUM_LINES    = WAYS * NUM_SETS;
    localparam int MAX_GAP      = 6;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 10;
    localparam int NUM_TAGS     = 12;
    localparam int NUM_HOT_SETS = 3;
    localparam int PHASE_ITEMS  = 240;
    localparam int MAX_REPORTS  = 40;
    localparam int FILL_SET     = 5;

    localparam logic [ADDR_BITS-1:0] ADDR_ONE = 1;

    // One result word, unpacked.
    typedef struct packed {
        logic                 hit;
        logic [1:0]           line_state;
        logic                 victim_valid;
        logic [ADDR_BITS-1:0] victim_address;
        logic [1:0]           victim_state;
    } access_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals of the block. Every input has a known value
    // from time zero on.
    // ------------------------------------------------------------------------
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata   = '0;
    logic [1:0]               s_tuser   = CMD_LOOKUP;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [OFFSET_BITS-1:0]   cfg_data  = OFFSET_RESET;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    set_assoc_tag_store_lru u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // address, new_state, touch, ref_time, zero fill
        .s_tuser   (s_tuser),   // cmd
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // hit, line_state, victim_valid, victim_address,
                                // victim_state, zero fill
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the tag store. Entry index is set * WAYS + way, as in the
    // block. The offset width follows every accepted register write.
    // ------------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] shadow_offset;
    logic [ADDR_BITS-1:0]   shadow_addr  [NUM_LINES];
    logic [1:0]             shadow_state [NUM_LINES];
    logic [STAMP_BITS-1:0]  shadow_stamp [NUM_LINES];

    // Result words still owed by the block, oldest first.
    access_result_t expected_results [$];

    int errors         = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;
    int offset_writes  = 0;
    int idle_cycles    = 0;

    // When set, that side of the stream never idles: these give the runs of
    // back-to-back words between the randomly paced stretches.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    // Running reference count used as the LRU timestamp.
    logic [STAMP_BITS-1:0] ref_clock = '0;

    // Tags and sets that the random traffic concentrates on. Twelve tags over
    // three sets of eight ways keep every set full and evicting.
    logic [ADDR_BITS-1:0] tag_pool [NUM_TAGS];
    int                   hot_sets [NUM_HOT_SETS];

    // ------------------------------------------------------------------------
    // Predicts the result of one command and updates the shadow store.
    // A hit takes the lowest matching way. A set-state miss fills the highest
    // free way, or else replaces the valid way with the smallest timestamp,
    // the lowest way on a tie. Command three reads like a lookup that never
    // refreshes the timestamp.
    // ------------------------------------------------------------------------
    function automatic access_result_t tag_store_access(cmd_t cmd,
            logic [ADDR_BITS-1:0] addr, logic [1:0] nst, logic touch,
            logic [STAMP_BITS-1:0] now);
        access_result_t        r;
        logic [ADDR_BITS-1:0]  shifted;
        logic [STAMP_BITS-1:0] oldest_stamp;
        int                    tshift;
        int                    base;
        int                    match;
        int                    free_way;
        int                    oldest;
        int                    e;
        r              = '0;
        r.line_state   = LS_INVALID;
        r.victim_state = LS_INVALID;
        tshift  = int'(shadow_offset) + SET_BITS;
        shifted = addr >> shadow_offset;
        base    = int'(shifted[SET_IDX_BITS-1:0]) * WAYS;

        match = -1;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (shadow_state[base + w] != LS_INVALID &&
                (shadow_addr[base + w] >> tshift) == (addr >> tshift))
                match = w;
        end

        if (match >= 0)
        begin
            e            = base + match;
            r.hit        = 1'b1;
            r.line_state = shadow_state[e];
            if (cmd == CMD_LOOKUP)
            begin
                if (touch)
                    shadow_stamp[e] = now;
            end
            else if (cmd == CMD_SET || cmd == CMD_SET_HIT)
                shadow_state[e] = nst;
        end
        else if (cmd == CMD_SET && nst != LS_INVALID)
        begin
            free_way     = -1;
            oldest       = 0;
            oldest_stamp = shadow_stamp[base];
            for (int w = 0; w < WAYS; w++)
            begin
                if (shadow_state[base + w] == LS_INVALID)
                    free_way = w;
                else if (shadow_stamp[base + w] < oldest_stamp)
                begin
                    oldest_stamp = shadow_stamp[base + w];
                    oldest       = w;
                end
            end
            if (free_way >= 0)
                e = base + free_way;
            else
            begin
                e                = base + oldest;
                r.victim_valid   = 1'b1;
                r.victim_address = shadow_addr[e];
                r.victim_state   = shadow_state[e];
            end
            shadow_addr[e]  = addr;
            shadow_stamp[e] = now;
            shadow_state[e] = nst;
        end
        return r;
    endfunction

    // Builds an address that lands in the given set with the given tag under
    // the current offset width. The line offset bits are random.
    function automatic logic [ADDR_BITS-1:0] make_line_address(int set_idx,
            logic [ADDR_BITS-1:0] tag);
        logic [63:0]          raw;
        logic [ADDR_BITS-1:0] set_field;
        logic [ADDR_BITS-1:0] low;
        raw       = {$urandom, $urandom};
        set_field = '0;
        set_field[SET_IDX_BITS-1:0] = set_idx[SET_IDX_BITS-1:0];
        low       = raw[ADDR_BITS-1:0] & ((ADDR_ONE << shadow_offset) - ADDR_ONE);
        return (tag << (int'(shadow_offset) + SET_BITS)) |
               (set_field << shadow_offset) | low;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Called right after a rising edge; returns at the edge that took
    // the word. A word that follows with no gap keeps s_tvalid high.
    // ------------------------------------------------------------------------
    task automatic send_access(cmd_t cmd, logic [ADDR_BITS-1:0] addr,
            logic [1:0] nst, logic touch, logic [STAMP_BITS-1:0] now);
        logic [IN_DATA_BITS-1:0] word;
        access_result_t          predicted;
        int                      gap;
        gap  = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        word = '0;
        word[IN_ADDR_LSB +: ADDR_BITS]   = addr;
        word[IN_NST_LSB +: 2]            = nst;
        word[IN_TOUCH_LSB]               = touch;
        word[IN_TIME_LSB +: STAMP_BITS]  = now;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        predicted        = tag_store_access(cmd, addr, nst, touch, now);
        expected_results = {expected_results, predicted};
        items_sent++;
    endtask

    // Holds off new commands until every result word has come back, then lets
    // the block settle before it returns.
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the offset width register. Only ever done with the block idle.
    task automatic write_offset(logic [OFFSET_BITS-1:0] value);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_offset = value;
        offset_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver. For every result word it draws a stall, then holds m_tready
    // high until a word is taken.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Every result word taken is compared field by field with the oldest
    // prediction.
    always @(posedge clk)
    begin : result_check
        access_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, got %h",
                             $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_seen++;
                hits_seen      += want.hit;
                evictions_seen += want.victim_valid;
                check_field("hit", want.hit, m_tdata[OUT_HIT_LSB]);
                check_field("line_state", want.line_state, m_tdata[OUT_LSTATE_LSB +: 2]);
                check_field("victim_valid", want.victim_valid, m_tdata[OUT_VVALID_LSB]);
                check_field("victim_address", want.victim_address,
                            m_tdata[OUT_VADDR_LSB +: ADDR_BITS]);
                check_field("victim_state", want.victim_state,
                            m_tdata[OUT_VSTATE_LSB +: 2]);
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no word accepted for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Fills one set with eight lines of increasing timestamp, refreshes the
    // oldest, then allocates a ninth line: the second oldest must be evicted.
    task automatic test_fill_and_evict();
        ref_clock = 100;
        for (int w = 0; w < WAYS; w++)
        begin
            send_access(CMD_SET, make_line_address(FILL_SET, ADDR_BITS'(w + 1)),
                        2'(w % 3), 1'b0, ref_clock);
            ref_clock++;
        end
        ref_clock = 200;
        send_access(CMD_LOOKUP, make_line_address(FILL_SET, ADDR_BITS'(1)), ST_MODIFIED,
                    1'b1, ref_clock);
        send_access(CMD_SET, make_line_address(FILL_SET, ADDR_BITS'(9)), ST_EXCLUSIVE,
                    1'b0, ref_clock + 1);
        send_access(CMD_LOOKUP, make_line_address(FILL_SET, ADDR_BITS'(2)), ST_MODIFIED,
                    1'b1, ref_clock + 2);
        // Command three peeks without refreshing the line.
        send_access(CMD_PEEK, make_line_address(FILL_SET, ADDR_BITS'(3)), ST_SHARED,
                    1'b1, ref_clock + 3);
        ref_clock += 4;
    endtask

    // State changes on hits and misses, including freeing a way by writing
    // the invalid state and a miss that must leave the set untouched.
    task automatic test_state_changes();
        send_access(CMD_SET_HIT, make_line_address(FILL_SET, ADDR_BITS'(2)), ST_MODIFIED,
                    1'b0, ref_clock);
        send_access(CMD_SET_HIT, make_line_address(FILL_SET, ADDR_BITS'(3)), ST_SHARED,
                    1'b0, ref_clock);
        send_access(CMD_SET, make_line_address(FILL_SET, ADDR_BITS'(4)), LS_INVALID,
                    1'b0, ref_clock);
        send_access(CMD_SET, make_line_address(FILL_SET, ADDR_BITS'(10)), LS_INVALID,
                    1'b0, ref_clock);
        send_access(CMD_SET, make_line_address(FILL_SET, ADDR_BITS'(10)), ST_EXCLUSIVE,
                    1'b0, ref_clock + 1);
        send_access(CMD_LOOKUP, make_line_address(FILL_SET, ADDR_BITS'(3)), ST_MODIFIED,
                    1'b0, ref_clock + 2);
        ref_clock += 3;
    endtask

    // All-ones and all-zero addresses and timestamps.
    task automatic test_field_extremes();
        send_access(CMD_SET, '1, ST_MODIFIED, 1'b1, '1);
        send_access(CMD_SET, '0, ST_SHARED, 1'b0, '0);
        send_access(CMD_LOOKUP, '1, LS_INVALID, 1'b1, '0);
    endtask

    // Two lines stored with offset zero alias once the offset grows by one:
    // both then match the same lookup and the lower way must win.
    task automatic test_offset_alias();
        write_offset(4'd0);
        send_access(CMD_SET, ADDR_BITS'(0), ST_MODIFIED, 1'b0, ref_clock);
        send_access(CMD_SET, ADDR_BITS'('h40), ST_SHARED, 1'b0, ref_clock + 1);
        write_offset(4'd1);
        send_access(CMD_LOOKUP, ADDR_BITS'(0), ST_MODIFIED, 1'b1, ref_clock + 2);
        ref_clock += 3;
    endtask

    // ------------------------------------------------------------------------
    // Random traffic under one offset width. Most commands hit a few busy
    // sets with a small tag pool so that lines hit, fill and get evicted; a
    // few go to random addresses. Halfway through, the sender drains the
    // block completely before it goes on.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(logic [OFFSET_BITS-1:0] offset, int count,
            int pacing);
        logic [63:0]          raw;
        logic [ADDR_BITS-1:0] addr;
        logic [1:0]           nst;
        cmd_t                 cmd;
        int                   roll;
        write_offset(offset);
        tx_steady = pacing[0];
        rx_steady = pacing[1];
        for (int i = 0; i < NUM_HOT_SETS; i++)
            hot_sets[i] = $urandom_range(0, NUM_SETS - 1);
        for (int i = 0; i < NUM_TAGS; i++)
        begin
            raw         = {$urandom, $urandom};
            tag_pool[i] = raw[ADDR_BITS-1:0];
        end
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain_and_settle();
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                raw  = {$urandom, $urandom};
                addr = raw[ADDR_BITS-1:0];
            end
            else
                addr = make_line_address(hot_sets[$urandom_range(0, NUM_HOT_SETS - 1)],
                                         tag_pool[$urandom_range(0, NUM_TAGS - 1)]);
            roll = $urandom_range(0, 99);
            if (roll < 35)
                cmd = CMD_LOOKUP;
            else if (roll < 70)
                cmd = CMD_SET;
            else if (roll < 90)
                cmd = CMD_SET_HIT;
            else
                cmd = CMD_PEEK;
            nst = ($urandom_range(0, 99) < 15) ? LS_INVALID : 2'($urandom_range(0, 2));
            // Small steps give ties; an occasional jump scrambles the age order.
            if ($urandom_range(0, 9) == 0)
                ref_clock = $urandom;
            else
                ref_clock += $urandom_range(0, 3);
            send_access(cmd, addr, nst, 1'($urandom_range(0, 1)), ref_clock);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [OFFSET_BITS-1:0] phase_offsets [8];
        for (int e = 0; e < NUM_LINES; e++)
        begin
            shadow_addr[e]  = '0;
            shadow_state[e] = LS_INVALID;
            shadow_stamp[e] = '0;
        end
        shadow_offset = OFFSET_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_state_changes();
        test_field_extremes();
        test_offset_alias();

        // Offsets from the smallest to the largest the register holds, the
        // reset value and one random middle value.
        phase_offsets = '{4'd15, 4'd0, 4'd12, 4'd13, 4'd6, 4'd14, 4'd9,
                          4'($urandom_range(1, 11))};
        for (int p = 0; p < 8; p++)
            test_random_traffic(phase_offsets[p], PHASE_ITEMS, p % 4);

        drain_and_settle();
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, expected_results.size());
            errors += expected_results.size();
        end

        $display("Sent %0d commands under %0d offset register writes, checked %0d results.",
                 items_sent, offset_writes, results_seen);
        $display("The results held %0d hits and %0d evictions, with %0d mismatches.",
                 hits_seen, evictions_seen, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/satslru_pkg.sv
hdl/satslru_ram.sv
hdl/set_assoc_tag_store_lru.sv
dv/tb.sv
